### rtl/rpr_pkg.sv
// shared types, sizes and tables for the record point rotator
`default_nettype none
package rpr_pkg;

   localparam int BUFFER_BYTES        = 4096;
   localparam int MAX_BYTES_PER_POINT = 16;
   localparam int BUF_AW              = $clog2(BUFFER_BYTES);
   localparam int MEM_AW              = BUF_AW + 1;
   localparam int BPP_W               = 5;
   localparam int PPR_W               = 13;
   localparam int ROT_W               = 12;
   localparam int CSR_IDX_W           = 2;
   localparam int CSR_DATA_W          = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_POINT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_PER_RECORD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_POINTS     = 2'd2;

   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       record_end;
   } rsp_type;

   // largest point count that fits the buffer for a clamped point size
   function automatic logic [PPR_W-1:0] points_limit(input logic [BPP_W-1:0] b);
      logic [PPR_W-1:0] lim;
      case (b)
         5'd1:    lim = PPR_W'(BUFFER_BYTES / 1);
         5'd2:    lim = PPR_W'(BUFFER_BYTES / 2);
         5'd3:    lim = PPR_W'(BUFFER_BYTES / 3);
         5'd4:    lim = PPR_W'(BUFFER_BYTES / 4);
         5'd5:    lim = PPR_W'(BUFFER_BYTES / 5);
         5'd6:    lim = PPR_W'(BUFFER_BYTES / 6);
         5'd7:    lim = PPR_W'(BUFFER_BYTES / 7);
         5'd8:    lim = PPR_W'(BUFFER_BYTES / 8);
         5'd9:    lim = PPR_W'(BUFFER_BYTES / 9);
         5'd10:   lim = PPR_W'(BUFFER_BYTES / 10);
         5'd11:   lim = PPR_W'(BUFFER_BYTES / 11);
         5'd12:   lim = PPR_W'(BUFFER_BYTES / 12);
         5'd13:   lim = PPR_W'(BUFFER_BYTES / 13);
         5'd14:   lim = PPR_W'(BUFFER_BYTES / 14);
         5'd15:   lim = PPR_W'(BUFFER_BYTES / 15);
         5'd16:   lim = PPR_W'(BUFFER_BYTES / 16);
         default: lim = PPR_W'(BUFFER_BYTES);
      endcase
      return lim;
   endfunction

endpackage
`default_nettype wire

### rtl/record_point_rotator_unit.sv
// record point rotator: ping-pong byte store, rotated drain, config recompute
//
// A data beat writes its byte into the filling half of an 8 KiB single-clock
// store, and in the same cycle any accepted beat reads one byte of the
// completed record from the other half; the read data is registered and
// reaches a two-entry output queue in the following cycle, so with the result
// side ready and no recompute running the block takes a beat every cycle.
// After reset and after every configuration write the block derives the
// clamped point size, point count, rotation, record length and the drain
// position (a 12-step bit-serial remainder of the drain point by the point
// count); req_ready is low during that time and configuration writes are
// taken as ever. The store has no reset; a record is only read after it has
// been completely written.
`default_nettype none
module record_point_rotator_unit
   import rpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EFF  = 3'd1;
   localparam logic [2:0] ST_LEN  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_SRC  = 3'd4;
   localparam logic [2:0] ST_BASE = 3'd5;

   localparam int DIV_CW = $clog2(ROT_W);

   // configuration registers
   logic [BPP_W-1:0] bpp_ff, bpp_in;
   logic [PPR_W-1:0] ppr_ff, ppr_in;
   logic [ROT_W-1:0] rot_ff, rot_in;

   // derived configuration
   logic [BPP_W-1:0]  b_ff, b_in;
   logic [PPR_W-1:0]  n_ff, n_in;
   logic [ROT_W-1:0]  r_ff, r_in;
   logic [ROT_W-1:0]  start_src_ff, start_src_in;
   logic [BUF_AW-1:0] start_base_ff, start_base_in;
   logic [PPR_W-1:0]  len_ff, len_in;

   // recompute sequencer
   logic [2:0]        state_ff, state_in;
   logic [DIV_CW-1:0] div_cnt_ff, div_cnt_in;
   logic [PPR_W-1:0]  div_rem_ff, div_rem_in;

   // record state
   logic              fill_half_ff, fill_half_in;
   logic [PPR_W-1:0]  wpos_ff, wpos_in;
   logic [ROT_W-1:0]  dpoint_ff, dpoint_in;
   logic [3:0]        dbyte_ff, dbyte_in;
   logic [PPR_W-1:0]  drem_ff, drem_in;
   logic [ROT_W-1:0]  src_ff, src_in;
   logic [BUF_AW-1:0] base_ff, base_in;

   // store and read pipe
   logic [7:0]        store_mem [2*BUFFER_BYTES];
   logic [7:0]        rd_data_ff;
   logic              rd_end_ff, rd_end_in;
   logic              inflight_ff, inflight_in;

   // output queue
   rsp_type           q_ff [2];
   logic              head_ff, head_in;
   logic [1:0]        count_ff, count_in;

   logic              accept, drain_step, pop, push, wr_en;
   logic [MEM_AW-1:0] waddr, raddr;
   logic [BUF_AW:0]   off_sum;
   logic [PPR_W:0]    wpos_inc;
   logic [4:0]        dbyte_inc;
   logic [ROT_W:0]    src_inc;
   logic [PPR_W-1:0]  shifted;
   logic [PPR_W+1:0]  src_sum;
   logic [BPP_W-1:0]  b_clamp;
   logic [PPR_W-1:0]  lim, n_clamp;
   logic [ROT_W-1:0]  r_clamp;
   logic [PPR_W-1:0]  n_minus1;
   logic [BUF_AW+BPP_W:0] prod_base;
   logic [PPR_W+BPP_W-1:0] prod_len;
   logic [ROT_W+BPP_W-1:0] prod_src;

   assign pop        = rsp_valid && rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) &&
                       ((3'(count_ff) + 3'(inflight_ff) - 3'(pop)) < 3'd2);
   assign accept     = req_valid && req_ready;
   assign drain_step = accept && (drem_ff != '0);
   assign wr_en      = accept && (req_data.opcode == OP_DATA);
   assign push       = inflight_ff;

   assign off_sum = (BUF_AW+1)'(base_ff) + (BUF_AW+1)'(dbyte_ff);
   assign raddr   = {~fill_half_ff, off_sum[BUF_AW-1:0]};
   assign waddr   = {fill_half_ff, wpos_ff[BUF_AW-1:0]};

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = q_ff[head_ff];

   always_comb begin
      bpp_in = bpp_ff;
      ppr_in = ppr_ff;
      rot_in = rot_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BYTES_PER_POINT:   bpp_in = csr_wdata[BPP_W-1:0];
            CSR_POINTS_PER_RECORD: ppr_in = csr_wdata[PPR_W-1:0];
            CSR_ROTATE_POINTS:     rot_in = csr_wdata[ROT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp chain for the derived configuration
   always_comb begin
      if (bpp_ff == '0) begin
         b_clamp = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_BYTES_PER_POINT)) begin
         b_clamp = BPP_W'(MAX_BYTES_PER_POINT);
      end else begin
         b_clamp = bpp_ff;
      end
      lim = points_limit(b_clamp);
      if (ppr_ff == '0) begin
         n_clamp = PPR_W'(1);
      end else if (ppr_ff > lim) begin
         n_clamp = lim;
      end else begin
         n_clamp = ppr_ff;
      end
      n_minus1 = n_clamp - PPR_W'(1);
      if (PPR_W'(rot_ff) > n_minus1) begin
         r_clamp = n_minus1[ROT_W-1:0];
      end else begin
         r_clamp = rot_ff;
      end
   end

   assign prod_len  = (PPR_W+BPP_W)'(n_ff) * (PPR_W+BPP_W)'(b_ff);
   assign prod_base = (BUF_AW+BPP_W+1)'(start_src_ff) * (BUF_AW+BPP_W+1)'(b_ff);
   assign prod_src  = (ROT_W+BPP_W)'(src_ff) * (ROT_W+BPP_W)'(b_ff);
   assign shifted   = {div_rem_ff[PPR_W-2:0], dpoint_ff[div_cnt_ff]};
   assign src_sum   = (PPR_W+2)'(div_rem_ff) + (PPR_W+2)'(n_ff) - (PPR_W+2)'(r_ff);
   assign wpos_inc  = (PPR_W+1)'(wpos_ff) + (PPR_W+1)'(1);
   assign dbyte_inc = 5'(dbyte_ff) + 5'd1;
   assign src_inc   = (ROT_W+1)'(src_ff) + (ROT_W+1)'(1);

   always_comb begin
      state_in      = state_ff;
      div_cnt_in    = div_cnt_ff;
      div_rem_in    = div_rem_ff;
      b_in          = b_ff;
      n_in          = n_ff;
      r_in          = r_ff;
      start_src_in  = start_src_ff;
      start_base_in = start_base_ff;
      len_in        = len_ff;
      fill_half_in  = fill_half_ff;
      wpos_in       = wpos_ff;
      dpoint_in     = dpoint_ff;
      dbyte_in      = dbyte_ff;
      drem_in       = drem_ff;
      src_in        = src_ff;
      base_in       = base_ff;
      rd_end_in     = rd_end_ff;

      unique case (state_ff)
         ST_IDLE: ;
         ST_EFF: begin
            b_in = b_clamp;
            n_in = n_clamp;
            r_in = r_clamp;
            start_src_in = (r_clamp == '0) ? '0 : ROT_W'(n_clamp - PPR_W'(r_clamp));
            state_in = ST_LEN;
         end
         ST_LEN: begin
            start_base_in = prod_base[BUF_AW-1:0];
            len_in        = prod_len[PPR_W-1:0];
            div_rem_in    = '0;
            div_cnt_in    = DIV_CW'(ROT_W - 1);
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit a cycle of drain_point mod point count
            if (shifted >= n_ff) begin
               div_rem_in = shifted - n_ff;
            end else begin
               div_rem_in = shifted;
            end
            if (div_cnt_ff == '0) begin
               state_in = ST_SRC;
            end else begin
               div_cnt_in = div_cnt_ff - DIV_CW'(1);
            end
         end
         ST_SRC: begin
            if (src_sum >= (PPR_W+2)'(n_ff)) begin
               src_in = ROT_W'(src_sum - (PPR_W+2)'(n_ff));
            end else begin
               src_in = ROT_W'(src_sum);
            end
            state_in = ST_BASE;
         end
         ST_BASE: begin
            base_in  = prod_src[BUF_AW-1:0];
            state_in = ST_IDLE;
         end
         default: state_in = ST_EFF;
      endcase

      if (drain_step) begin
         drem_in   = drem_ff - PPR_W'(1);
         rd_end_in = (drem_ff == PPR_W'(1));
         if (dbyte_inc >= 5'(b_ff)) begin
            dbyte_in  = '0;
            dpoint_in = dpoint_ff + ROT_W'(1);
            if (src_inc >= (ROT_W+1)'(n_ff)) begin
               src_in  = '0;
               base_in = '0;
            end else begin
               src_in  = src_inc[ROT_W-1:0];
               base_in = base_ff + BUF_AW'(b_ff);
            end
         end else begin
            dbyte_in = dbyte_inc[3:0];
         end
      end

      if (wr_en) begin
         // a completed record overrides whatever the drain left
         if (wpos_inc >= (PPR_W+1)'(len_ff)) begin
            fill_half_in = ~fill_half_ff;
            wpos_in      = '0;
            dpoint_in    = '0;
            dbyte_in     = '0;
            drem_in      = len_ff;
            src_in       = start_src_ff;
            base_in      = start_base_ff;
         end else begin
            wpos_in = wpos_inc[PPR_W-1:0];
         end
      end

      if (csr_wr_en) begin
         state_in = ST_EFF;
      end
   end

   always_comb begin
      inflight_in = drain_step;
      head_in     = head_ff ^ pop;
      count_in    = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_W'(4);
         ppr_ff       <= PPR_W'(1024);
         rot_ff       <= ROT_W'(1);
         state_ff     <= ST_EFF;
         fill_half_ff <= 1'b0;
         wpos_ff      <= '0;
         dpoint_ff    <= '0;
         dbyte_ff     <= '0;
         drem_ff      <= '0;
         src_ff       <= '0;
         base_ff      <= '0;
         inflight_ff  <= 1'b0;
         head_ff      <= 1'b0;
         count_ff     <= '0;
      end else begin
         bpp_ff       <= bpp_in;
         ppr_ff       <= ppr_in;
         rot_ff       <= rot_in;
         state_ff     <= state_in;
         fill_half_ff <= fill_half_in;
         wpos_ff      <= wpos_in;
         dpoint_ff    <= dpoint_in;
         dbyte_ff     <= dbyte_in;
         drem_ff      <= drem_in;
         src_ff       <= src_in;
         base_ff      <= base_in;
         inflight_ff  <= inflight_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff    <= div_cnt_in;
      div_rem_ff    <= div_rem_in;
      b_ff          <= b_in;
      n_ff          <= n_in;
      r_ff          <= r_in;
      start_src_ff  <= start_src_in;
      start_base_ff <= start_base_in;
      len_ff        <= len_in;
      rd_end_ff     <= rd_end_in;
      if (push) begin
         q_ff[head_ff ^ count_ff[0]] <= '{out_byte: rd_data_ff, record_end: rd_end_ff};
      end
   end

   // byte store: write into the filling half, read the completed half
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[waddr] <= req_data.data_byte;
      end
      if (drain_step) begin
         rd_data_ff <= store_mem[raddr];
      end
   end

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("beat accepted during config recompute");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (3'(count_ff) + 3'(inflight_ff)) <= 3'd2)
      else $error("output queue overcommitted");

   a_drain_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      drain_step |=> (inflight_ff ##1 (count_ff != 2'd0)))
      else $error("drained byte did not reach the output queue");

   a_src_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && drem_ff != '0) |-> (PPR_W'(src_ff) < n_ff))
      else $error("drain source point out of range");

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench for the record point rotator: every output beat checked against an in-bench model
module testbench;
   import rpr_pkg::*;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   record_point_rotator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the ping-pong store and the drain position
   logic [7:0]       store_copy [2*BUFFER_BYTES];
   logic             fill_sel     = 1'b0;
   int unsigned      fill_pos     = 0;
   int unsigned      out_point    = 0;
   int unsigned      out_byte_idx = 0;
   int unsigned      drain_left   = 0;
   logic [BPP_W-1:0] shape_bpp    = 5'd4;
   logic [PPR_W-1:0] shape_ppr    = 13'd1024;
   logic [ROT_W-1:0] shape_rot    = 12'd1;

   rsp_type rotated_due[$];
   int      mismatches  = 0;
   int      cycle_count = 0;
   bit      send_calm   = 1'b0;
   bit      recv_calm   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one accepted beat: release a byte of the completed record, then store the new byte
   function automatic void rotate_accept(input req_type item);
      int unsigned b;
      int unsigned n;
      int unsigned r;
      int unsigned len;
      int unsigned src;
      int unsigned offset;
      rsp_type     beat;
      b = 32'(shape_bpp);
      if (b < 1) b = 1;
      if (b > MAX_BYTES_PER_POINT) b = MAX_BYTES_PER_POINT;
      if (b > BUFFER_BYTES) b = BUFFER_BYTES;
      n = 32'(shape_ppr);
      if (n < 1) n = 1;
      if (n > BUFFER_BYTES / b) n = BUFFER_BYTES / b;
      r = 32'(shape_rot);
      if (r > n - 1) r = n - 1;
      len = n * b;
      if (drain_left != 0) begin
         src = (out_point % n + n - r) % n;
         offset = (src * b + out_byte_idx) % BUFFER_BYTES;
         beat.out_byte = store_copy[MEM_AW'((fill_sel ? 0 : BUFFER_BYTES) + offset)];
         drain_left--;
         beat.record_end = (drain_left == 0);
         out_byte_idx++;
         if (out_byte_idx >= b) begin
            out_byte_idx = 0;
            out_point++;
         end
         rotated_due.push_back(beat);
      end
      if (item.opcode == OP_DATA) begin
         store_copy[MEM_AW'((fill_sel ? BUFFER_BYTES : 0) + fill_pos % BUFFER_BYTES)] =
            item.data_byte;
         fill_pos++;
         if (fill_pos >= len) begin
            fill_sel = ~fill_sel;
            fill_pos = 0;
            out_point = 0;
            out_byte_idx = 0;
            drain_left = len;
         end
      end
   endfunction

   task automatic send_item(input logic op, input logic [7:0] value);
      int      gap;
      req_type item;
      if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.opcode = op;
      item.data_byte = value;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rotate_accept(req_data);
   endtask

   // hold the sender until every expected beat is back and the pipeline is empty
   task automatic quiesce();
      req_valid <= 1'b0;
      while (rotated_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic drain_pending();
      while (drain_left != 0) send_item(OP_FLUSH, 8'($urandom));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_BYTES_PER_POINT:   shape_bpp = value[BPP_W-1:0];
         CSR_POINTS_PER_RECORD: shape_ppr = value;
         CSR_ROTATE_POINTS:     shape_rot = value[ROT_W-1:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits carry junk, the block must ignore them
   task automatic set_shape(input logic [BPP_W-1:0] b, input logic [PPR_W-1:0] n,
                            input logic [ROT_W-1:0] r);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_BYTES_PER_POINT, {junk[CSR_DATA_W-1:BPP_W], b});
      write_csr(CSR_POINTS_PER_RECORD, n);
      junk = CSR_DATA_W'($urandom);
      write_csr(CSR_ROTATE_POINTS, {junk[CSR_DATA_W-1:ROT_W], r});
   endtask

   // part of a record under the reset shape gives no beat; then keep the reset
   // point size and rotation but shorten the record so it completes
   task automatic test_reset_shape();
      repeat (2) send_item(OP_FLUSH, 8'hFF);
      repeat (24) send_item(OP_DATA, 8'($urandom));
      quiesce();
      write_csr(CSR_POINTS_PER_RECORD, 13'd3);
      repeat (12) send_item(OP_DATA, 8'($urandom));
      drain_pending();
   endtask

   task automatic test_small_records();
      quiesce();
      set_shape(5'd2, 13'd2, 12'd1);
      send_item(OP_FLUSH, 8'h00);
      send_item(OP_DATA, 8'h00);
      send_item(OP_DATA, 8'hFF);
      send_item(OP_DATA, 8'h5A);
      send_item(OP_DATA, 8'hA5);
      drain_pending();
      send_item(OP_FLUSH, 8'h00);
   endtask

   // zero size and count clamp to one, rotation saturates to zero
   task automatic test_degenerate_shapes();
      quiesce();
      set_shape(5'd0, 13'd0, 12'hFFF);
      write_csr(CSR_SPARE, 13'h1FFF);
      send_item(OP_DATA, 8'h80);
      send_item(OP_DATA, 8'h01);
      drain_pending();
      send_item(OP_FLUSH, 8'h7F);
   endtask

   // shorten the record while the previous one is still draining
   task automatic test_record_overrun();
      quiesce();
      set_shape(5'd1, 13'd8, 12'd3);
      repeat (8) send_item(OP_DATA, 8'($urandom));
      quiesce();
      write_csr(CSR_POINTS_PER_RECORD, 13'd4);
      repeat (4) send_item(OP_DATA, 8'($urandom));
      drain_pending();
   endtask

   task automatic test_random_records();
      int               sent;
      int               phase_len;
      logic [BPP_W-1:0] b;
      logic [PPR_W-1:0] n;
      logic [ROT_W-1:0] r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiesce();
         b = BPP_W'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 4)
                                                 : $urandom_range(0, 31));
         n = PPR_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 8)
                                                 : $urandom_range(9, 40));
         r = ROT_W'(($urandom_range(0, 7) != 0) ? $urandom_range(0, n + 1)
                                                 : $urandom_range(0, 4095));
         set_shape(b, n, r);
         // phases end mid-record, so the next shape lands on a partly filled half
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            if ($urandom_range(0, 59) == 0) quiesce();
            if ($urandom_range(0, 6) == 0) send_item(OP_FLUSH, 8'($urandom));
            else send_item(OP_DATA, 8'($urandom));
            sent++;
         end
         while (drain_left != 0) begin
            send_item(OP_FLUSH, 8'($urandom));
            sent++;
         end
      end
   endtask

   // widest points with huge count and rotation: fill part of a record, then
   // shrink the count so the overlong fill completes on the next byte
   task automatic test_largest_records();
      quiesce();
      set_shape(5'd31, 13'h1FFF, 12'hFFF);
      repeat (40) send_item(OP_DATA, 8'($urandom));
      quiesce();
      write_csr(CSR_POINTS_PER_RECORD, 13'd2);
      send_item(OP_DATA, 8'($urandom));
      drain_pending();
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
         stall = recv_calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         if (rotated_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none, got byte %02h end %0b",
                     $time, rsp_data.out_byte, rsp_data.record_end);
         end else begin
            want = rotated_due.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               mismatches++;
               $display("%0t: out_byte expected %02h got %02h",
                        $time, want.out_byte, rsp_data.out_byte);
            end
            if (rsp_data.record_end !== want.record_end) begin
               mismatches++;
               $display("%0t: record_end expected %0b got %0b",
                        $time, want.record_end, rsp_data.record_end);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_shape();
      test_small_records();
      test_degenerate_shapes();
      test_record_overrun();
      test_random_records();
      test_largest_records();
      quiesce();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### sim.f
rtl/rpr_pkg.sv
rtl/record_point_rotator_unit.sv
dv/testbench.sv
